@@ sv/mbd_pkg.sv @@
// Shared constants, types and lane arithmetic for the mip box downsampler.
`timescale 1ns / 1ps
package mbd_pkg;

   // Image limits
   localparam int MAX_WIDTH    = 4096;
   localparam int HEIGHT_LIMIT = 4096;

   // Register and counter widths
   localparam int DIM_W       = 13;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(HEIGHT_LIMIT);
   localparam int EW_W        = $clog2(MAX_WIDTH + 1);
   localparam int EH_W        = $clog2(HEIGHT_LIMIT + 1);
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Pixel and pair-sum layout
   localparam int LANES  = 4;
   localparam int LANE_W = 8;
   localparam int SUM_W  = LANE_W + 1;
   localparam int PIX_W  = LANES * LANE_W;
   localparam int PAIR_W = LANES * SUM_W;

   // Configuration port
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;

   typedef enum logic {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } reg_index_type;

   // Effective image size plus a restart strobe on any register write
   typedef struct packed {
      logic [EW_W-1:0] width;
      logic [EH_W-1:0] height;
      logic            restart;
   } cfg_type;

   // One accepted pixel with its row store and output decisions
   typedef struct packed {
      logic [PIX_W-1:0]  pix_a;
      logic [PIX_W-1:0]  pix_b;
      logic [ADDR_W-1:0] addr;
      logic              wr;
      logic              rd;
      logic              emit;
      logic              last;
   } step_type;

   // Per-lane 9-bit sums of two pixels
   function automatic logic [PAIR_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      logic [PAIR_W-1:0] r;
      r = '0;
      for (int i = 0; i < LANES; i++) begin
         r[i*SUM_W +: SUM_W] = {1'b0, a[i*LANE_W +: LANE_W]} +
                               {1'b0, b[i*LANE_W +: LANE_W]};
      end
      return r;
   endfunction

   // Rounded mean of two pair-sum words, packed back to 8-bit lanes
   function automatic logic [PIX_W-1:0] block_average(input logic [PAIR_W-1:0] p,
                                                      input logic [PAIR_W-1:0] q);
      logic [PIX_W-1:0] r;
      logic [SUM_W:0]   s;
      r = '0;
      for (int i = 0; i < LANES; i++) begin
         s = {1'b0, p[i*SUM_W +: SUM_W]} + {1'b0, q[i*SUM_W +: SUM_W]} +
             (SUM_W+1)'(2);
         r[i*LANE_W +: LANE_W] = s[LANE_W+1:2];
      end
      return r;
   endfunction

endpackage

@@ sv/mbd_if.sv @@
// Stream channel interfaces for source and result pixels.
`timescale 1ns / 1ps
interface mbd_req_if;
   import mbd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             last_pixel;

   modport source (output valid, output pixel_out, output last_pixel, input ready);
   modport sink (input valid, input pixel_out, input last_pixel, output ready);
endinterface

@@ sv/mbd_csr.sv @@
// APB register file: source width and height, effective size and restart strobe.
`timescale 1ns / 1ps
module mbd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mbd_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [mbd_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [mbd_pkg::APB_DATA_W-1:0]   prdata,
   output logic                             pready,
   output mbd_pkg::cfg_type                 cfg
);
   import mbd_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_beat;
   reg_index_type    reg_sel;

   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite && pready;
   assign reg_sel = reg_index_type'(paddr[2]);

   // Decode the write beat
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_beat) begin
         case (reg_sel)
            REG_SRC_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read back the raw register
   always_comb begin
      case (reg_sel)
         REG_SRC_WIDTH:  prdata = APB_DATA_W'(width_ff);
         REG_SRC_HEIGHT: prdata = APB_DATA_W'(height_ff);
         default:        prdata = '0;
      endcase
   end

   // Clamp zero to one and saturate at the limits
   always_comb begin
      if (width_ff == '0)
         cfg.width = EW_W'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         cfg.width = EW_W'(MAX_WIDTH);
      else
         cfg.width = EW_W'(width_ff);

      if (height_ff == '0)
         cfg.height = EH_W'(1);
      else if (32'(height_ff) > HEIGHT_LIMIT)
         cfg.height = EH_W'(HEIGHT_LIMIT);
      else
         cfg.height = EH_W'(height_ff);

      cfg.restart = wr_beat;
   end

endmodule

@@ sv/mbd_track.sv @@
// Raster position tracking, even-column pixel hold and per-pixel decisions.
`timescale 1ns / 1ps
module mbd_track (
   input  logic                        clock,
   input  logic                        reset,
   input  mbd_pkg::cfg_type            cfg,
   input  logic                        take,
   input  logic [mbd_pkg::PIX_W-1:0]   pixel,
   output mbd_pkg::step_type           step
);
   import mbd_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] held_ff, held_in;
   logic             w_one, h_one;
   logic             col_end, row_end;
   logic             col_last, row_last;
   logic             have_pair;

   assign w_one = (cfg.width == EW_W'(1));
   assign h_one = (cfg.height == EH_W'(1));

   // Position within the source image
   assign col_end  = (EW_W'(col_ff) + EW_W'(1)) >= cfg.width;
   assign row_end  = (EH_W'(row_ff) + EH_W'(1)) >= cfg.height;
   assign col_last = w_one || ((EW_W'(col_ff >> 1) + EW_W'(1)) == (cfg.width >> 1));
   assign row_last = h_one || ((EH_W'(row_ff >> 1) + EH_W'(1)) == (cfg.height >> 1));

   // Pair up columns; pass the row store and output decisions downstream
   assign have_pair = w_one || col_ff[0];
   always_comb begin
      step.pix_a = w_one ? pixel : held_ff;
      step.pix_b = pixel;
      step.addr  = w_one ? '0 : ADDR_W'(col_ff >> 1);
      step.emit  = have_pair && (h_one || row_ff[0]);
      step.wr    = have_pair && !h_one && !row_ff[0];
      step.rd    = have_pair && !h_one && row_ff[0];
      step.last  = col_last && row_last;
   end

   // Advance the counters and hold the even-column pixel
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (cfg.restart) begin
         col_in  = '0;
         row_in  = '0;
         held_in = '0;
      end else if (take) begin
         if (!w_one && !col_ff[0] && !col_end)
            held_in = pixel;
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
      end
   end

endmodule

@@ sv/mbd_row_store.sv @@
// Row store of even-row pair sums: one write port, one registered read port.
`timescale 1ns / 1ps
module mbd_row_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [mbd_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [mbd_pkg::PAIR_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [mbd_pkg::ADDR_W-1:0]   rd_addr,
   output logic [mbd_pkg::PAIR_W-1:0]   rd_data
);
   import mbd_pkg::*;

   logic [PAIR_W-1:0] mem [STORE_DEPTH];
   logic [PAIR_W-1:0] rd_data_ff;

   // Write the pair sum
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
   end

   // Read and hold until the next read
   always_ff @(posedge clock) begin
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/mipmap_box_downsample_unit.sv @@
// Top level of the 2x2 box-filter mip downsampler for RGBA8 pixel streams.
// Source pixels enter in raster order, one per clock while req_bus.ready is
// high. The result of a 2x2 block passes the decision and pair-sum registers
// and is presented from the result register. The sustained rate is one source
// pixel per cycle while rsp_bus.ready does not stall the output, set by the
// row store (2048 entries of four 9-bit pair sums, one write port and one read
// port), which takes one write or one read per pixel. The pipeline is an input
// decision register, a pair-sum stage that writes or reads the row store, and
// a result register that parts the two channels. The row store is not cleared
// after reset; in raster order every read follows the write of the same entry.
// Writing src_width or src_height (only while idle) restarts the pass at
// column and row zero. An odd last column or row of a width or height above
// one yields no result; last_pixel marks the final pixel of the output level.
`timescale 1ns / 1ps
module mipmap_box_downsample_unit (
   input  logic                             clock,
   input  logic                             reset,
   mbd_req_if.sink                          req_bus,
   mbd_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mbd_pkg::APB_ADDR_W-1:0]   paddr,
   input  logic [mbd_pkg::APB_DATA_W-1:0]   pwdata,
   output logic [mbd_pkg::APB_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import mbd_pkg::*;

   cfg_type           cfg;
   step_type          step;
   logic              take;

   step_type          s1_ff, s1_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [PAIR_W-1:0] s2_pair_ff, s2_pair_in;
   logic              s2_use_store_ff, s2_use_store_in;
   logic              s2_last_ff, s2_last_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [PIX_W-1:0]  out_pixel_ff, out_pixel_in;
   logic              out_last_ff, out_last_in;
   logic              out_valid_ff, out_valid_in;

   logic              out_free, s2_free, s1_free;
   logic              s1_go, s2_go;
   logic [PAIR_W-1:0] s1_pair;
   logic [PAIR_W-1:0] rd_data;

   mbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mbd_track u_track (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .take  (take),
      .pixel (req_bus.pixel_in),
      .step  (step)
   );

   // Stage handshakes
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s2_free       = !s2_valid_ff || out_free;
   assign s1_free       = !s1_valid_ff || s2_free;
   assign s2_go         = s2_valid_ff && out_free;
   assign s1_go         = s1_valid_ff && s2_free;
   assign req_bus.ready = s1_free;
   assign take          = req_bus.valid && req_bus.ready;

   // Sum the column pair
   assign s1_pair = pair_sum(s1_ff.pix_a, s1_ff.pix_b);

   mbd_row_store u_row_store (
      .clock   (clock),
      .wr_en   (s1_go && s1_ff.wr),
      .wr_addr (s1_ff.addr),
      .wr_data (s1_pair),
      .rd_en   (s1_go && s1_ff.rd),
      .rd_addr (s1_ff.addr),
      .rd_data (rd_data)
   );

   // Load the decision register on each accepted beat
   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = take;
         if (take)
            s1_in = step;
      end
   end

   // Keep only the pixels that produce a result
   always_comb begin
      s2_pair_in      = s2_pair_ff;
      s2_use_store_in = s2_use_store_ff;
      s2_last_in      = s2_last_ff;
      s2_valid_in     = s2_valid_ff;
      if (s2_free) begin
         s2_valid_in = s1_go && s1_ff.emit;
         if (s1_go) begin
            s2_pair_in      = s1_pair;
            s2_use_store_in = s1_ff.rd;
            s2_last_in      = s1_ff.last;
         end
      end
   end

   // Average the block into the result register
   always_comb begin
      out_pixel_in = out_pixel_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s2_valid_ff;
         if (s2_go) begin
            out_pixel_in = block_average(s2_use_store_ff ? rd_data : s2_pair_ff,
                                         s2_pair_ff);
            out_last_in  = s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff           <= s1_in;
      s2_pair_ff      <= s2_pair_in;
      s2_use_store_ff <= s2_use_store_in;
      s2_last_ff      <= s2_last_in;
      out_pixel_ff    <= out_pixel_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.pixel_out  = out_pixel_ff;
   assign rsp_bus.last_pixel = out_last_ff;

   // A pixel either fills the row store or reads it, never both
   a_store_access_exclusive: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_ff.wr && s1_ff.rd))
      else $error("row store write and read on the same pixel");

   // A store read always feeds a result
   a_read_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.rd) |-> s1_ff.emit)
      else $error("row store read without a result");

   // A new beat never overwrites a pixel still waiting in the decision register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      take |-> (!s1_valid_ff || s1_go))
      else $error("decision register overrun");

   // Stored pair sum holds while its result stalls
   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_go) |=> $stable(rd_data))
      else $error("row store read data lost under stall");

endmodule
